// ===== src/mhpq_pkg.sv =====
// Shared widths, opcodes and status codes of the min-heap priority queue.
`timescale 1ns / 1ps
package mhpq_pkg;

  localparam int OP_W   = 2;
  localparam int ID_W   = 10;
  localparam int COST_W = 32;
  localparam int POS_W  = 8;
  localparam int STAT_W = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT   = 2'd0,
    OP_POP      = 2'd1,
    OP_DECREASE = 2'd2,
    OP_NOP      = 2'd3
  } opcode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_ABSENT = 2'd3
  } status_t;

endpackage

// ===== src/mhpq_if.sv =====
// Valid/ready channel interfaces for request and result words.
`timescale 1ns / 1ps
interface mhpq_req_if import mhpq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [ID_W-1:0]   node_id;
  logic [COST_W-1:0] cost_value;

  modport source (output valid, opcode, node_id, cost_value, input ready);
  modport sink (input valid, opcode, node_id, cost_value, output ready);
endinterface

interface mhpq_rsp_if import mhpq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [ID_W-1:0]   out_node_id;
  logic [COST_W-1:0] out_cost;
  logic [POS_W-1:0]  out_position;

  modport source (output valid, status, out_node_id, out_cost, out_position, input ready);
  modport sink (input valid, status, out_node_id, out_cost, out_position, output ready);
endinterface

// ===== src/min_heap_priority_queue.sv =====
// Binary min-heap priority queue with a node-to-slot map, built around two memories.
//
// Channels: in_ch takes one request word (opcode, node_id, cost_value) when
// valid and ready are both high; out_ch delivers exactly one result word per
// request (status, out_node_id, out_cost, out_position).
// One request is worked on at a time. Each heap level of a sift reads the
// parent or children from the heap memory, whose read data is registered,
// then compares and writes back. Requests with an early answer skip the sift.
// After reset the block sweeps the position map, one entry per cycle, with
// in_ch.ready low; the heap starts empty.
// The result word sits in an output register; in_ch.ready stays low until
// that word has been taken, so the next request starts after the result
// appears and a stalled receiver holds off new requests.
`timescale 1ns / 1ps
module min_heap_priority_queue import mhpq_pkg::*; #(
  parameter int HEAP_DEPTH = 256,
  parameter int NODE_COUNT = 1024
) (
  input  logic     clk,
  input  logic     rst,
  mhpq_req_if.sink   in_ch,
  mhpq_rsp_if.source out_ch
);

  localparam int PW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam int NW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int LW = PW + 2;

  typedef struct packed {
    logic [NW-1:0]     node;
    logic [COST_W-1:0] cost;
  } entry_t;

  typedef struct packed {
    logic          valid;
    logic [PW-1:0] pos;
  } map_t;

  typedef enum logic [13:0] {
    S_CLEAR  = 14'b00000000000001,
    S_IDLE   = 14'b00000000000010,
    S_MAPRD  = 14'b00000000000100,
    S_DEC    = 14'b00000000001000,
    S_UP_RD  = 14'b00000000010000,
    S_UP_CMP = 14'b00000000100000,
    S_UP_END = 14'b00000001000000,
    S_P_TOP  = 14'b00000010000000,
    S_P_LAST = 14'b00000100000000,
    S_DN_L   = 14'b00001000000000,
    S_DN_R   = 14'b00010000000000,
    S_DN_CMP = 14'b00100000000000,
    S_DN_END = 14'b01000000000000,
    S_FIN    = 14'b10000000000000
  } state_t;

  // Memories
  entry_t heap_mem [HEAP_DEPTH];
  map_t   map_mem  [NODE_COUNT];
  entry_t heap_q;
  map_t   map_q;

  logic          heap_we;
  logic [PW-1:0] heap_wa;
  entry_t        heap_wd;
  logic [PW-1:0] heap_ra;
  logic          map_we;
  logic [NW-1:0] map_wa;
  map_t          map_wd;
  logic [NW-1:0] map_ra;

  // Control and working registers
  state_t            state;
  logic [CW-1:0]     count;
  logic [NW-1:0]     clr;
  opcode_t           op;
  logic [ID_W-1:0]   id;
  logic [COST_W-1:0] cost_in;
  entry_t            cur;
  entry_t            top;
  entry_t            lq;
  logic              hasr;
  logic [PW-1:0]     at;
  logic [PW-1:0]     up;
  status_t           res_status;
  logic [ID_W-1:0]   res_node;
  logic [COST_W-1:0] res_cost;
  logic [POS_W-1:0]  res_pos;
  logic              out_valid;

  logic              accept;
  logic              known;
  logic [LW-1:0]     left_w;
  logic [LW-1:0]     right_w;
  logic [LW-1:0]     count_w;
  logic [CW-1:0]     count_dec;
  logic              dn_right;
  entry_t            pick_e;
  logic [PW-1:0]     pick_a;
  logic              out_free;

  assign in_ch.ready = (state == S_IDLE) && !out_valid;
  assign accept      = in_ch.valid && in_ch.ready;
  assign known       = 32'(in_ch.node_id) < 32'(NODE_COUNT);
  assign left_w      = LW'({at, 1'b1});
  assign right_w     = left_w + LW'(1);
  assign count_w     = LW'(count);
  assign count_dec   = count - CW'(1);
  assign dn_right    = hasr && (lq.cost > heap_q.cost);
  assign pick_e      = dn_right ? heap_q : lq;
  assign pick_a      = dn_right ? PW'(right_w) : PW'(left_w);
  assign out_free    = !out_valid || out_ch.ready;

  // Memory port control
  always_comb begin
    heap_we = 1'b0;
    heap_wa = at;
    heap_wd = cur;
    heap_ra = '0;
    map_we  = 1'b0;
    map_wa  = cur.node;
    map_wd  = '{valid: 1'b1, pos: at};
    map_ra  = NW'(in_ch.node_id);
    case (state)
      S_CLEAR: begin
        map_we = 1'b1;
        map_wa = clr;
        map_wd = '0;
      end
      S_MAPRD: heap_ra = map_q.pos;
      S_UP_RD: heap_ra = PW'((at - PW'(1)) >> 1);
      S_UP_CMP: begin
        if (heap_q.cost > cur.cost) begin
          heap_we = 1'b1;
          heap_wd = heap_q;
          map_we  = 1'b1;
          map_wa  = heap_q.node;
        end
      end
      S_UP_END: begin
        heap_we = 1'b1;
        map_we  = 1'b1;
      end
      S_DN_END: begin
        // place the moved node only while the heap still holds entries
        heap_we = (count != '0);
        map_we  = (count != '0);
      end
      S_P_TOP: begin
        heap_ra = PW'(count_dec);
        map_we  = 1'b1;
        map_wa  = heap_q.node;
        map_wd  = '0;
      end
      S_DN_L: heap_ra = PW'(left_w);
      S_DN_R: heap_ra = PW'(right_w);
      S_DN_CMP: begin
        if (cur.cost > pick_e.cost) begin
          heap_we = 1'b1;
          heap_wd = pick_e;
          map_we  = 1'b1;
          map_wa  = pick_e.node;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (heap_we) begin
      heap_mem[heap_wa] <= heap_wd;
    end
    heap_q <= heap_mem[heap_ra];
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_wa] <= map_wd;
    end
    map_q <= map_mem[map_ra];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      count     <= '0;
      clr       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          clr <= clr + NW'(1);
          if (clr == NW'(NODE_COUNT - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op         <= opcode_t'(in_ch.opcode);
            id         <= in_ch.node_id;
            cost_in    <= in_ch.cost_value;
            res_status <= ST_OK;
            res_node   <= in_ch.node_id;
            res_cost   <= '0;
            res_pos    <= '0;
            case (opcode_t'(in_ch.opcode))
              OP_POP: begin
                if (count == '0) begin
                  res_status <= ST_EMPTY;
                  res_node   <= '0;
                  state      <= S_FIN;
                end else begin
                  state <= S_P_TOP;
                end
              end
              OP_INSERT, OP_DECREASE: begin
                if (!known) begin
                  res_status <= ST_ABSENT;
                  state      <= S_FIN;
                end else begin
                  state <= S_MAPRD;
                end
              end
              default: state <= S_FIN;
            endcase
          end
        end
        S_MAPRD: begin
          at <= map_q.pos;
          if (map_q.valid) begin
            state <= S_DEC;
          end else if (op == OP_DECREASE) begin
            res_status <= ST_ABSENT;
            state      <= S_FIN;
          end else if (count == CW'(HEAP_DEPTH)) begin
            res_status <= ST_FULL;
            res_cost   <= cost_in;
            state      <= S_FIN;
          end else begin
            // place new node in the last slot
            at       <= PW'(count);
            count    <= count + CW'(1);
            cur.node <= NW'(id);
            cur.cost <= cost_in;
            state    <= S_UP_RD;
          end
        end
        S_DEC: begin
          cur.node <= heap_q.node;
          cur.cost <= (heap_q.cost > cost_in) ? cost_in : heap_q.cost;
          state    <= S_UP_RD;
        end
        S_UP_RD: begin
          up    <= PW'((at - PW'(1)) >> 1);
          state <= (at == '0) ? S_UP_END : S_UP_CMP;
        end
        S_UP_CMP: begin
          if (heap_q.cost > cur.cost) begin
            at    <= up;
            state <= S_UP_RD;
          end else begin
            state <= S_UP_END;
          end
        end
        S_UP_END: begin
          res_cost <= cur.cost;
          res_pos  <= POS_W'(at);
          state    <= S_FIN;
        end
        S_P_TOP: begin
          top   <= heap_q;
          count <= count_dec;
          at    <= '0;
          state <= (count_dec == '0) ? S_DN_END : S_P_LAST;
        end
        S_P_LAST: begin
          cur   <= heap_q;
          state <= S_DN_L;
        end
        S_DN_L: begin
          state <= (count_w > left_w) ? S_DN_R : S_DN_END;
        end
        S_DN_R: begin
          lq    <= heap_q;
          hasr  <= count_w > right_w;
          state <= S_DN_CMP;
        end
        S_DN_CMP: begin
          if (cur.cost > pick_e.cost) begin
            at    <= pick_a;
            state <= S_DN_L;
          end else begin
            state <= S_DN_END;
          end
        end
        S_DN_END: begin
          // empty heap after pop leaves nothing to place
          res_node <= ID_W'(top.node);
          res_cost <= top.cost;
          state    <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Drive the result word
  assign out_ch.valid        = out_valid;
  assign out_ch.status       = res_status;
  assign out_ch.out_node_id  = res_node;
  assign out_ch.out_cost     = res_cost;
  assign out_ch.out_position = res_pos;

endmodule
